// File: hdl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, codes and constants shared by the packet frame checker modules.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned VerdictW  = 3;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [LenW-1:0] MaxLenReset = 16'd1024;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_LEN     = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_SUM_HI  = 3'd6,
    PH_SUM_LO  = 3'd7
  } phase_e;

  typedef enum logic [VerdictW-1:0] {
    V_VALID     = 3'd0,
    V_BAD_SYNC1 = 3'd1,
    V_BAD_SYNC2 = 3'd2,
    V_TOO_LONG  = 3'd3,
    V_BAD_SUM   = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [LenW-1:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    verdict_e         verdict;
    logic [ByteW-1:0] frame_type;
    logic [LenW-1:0]  length;
  } result_t;

endpackage

// File: hdl/pfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pfc_cfg_regs
// Write-only configuration registers of the packet frame checker.
// ----------------------------------------------------------------------------
module pfc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pfc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [pfc_pkg::CfgDataW-1:0]  cfg_data_i,
  output pfc_pkg::cfg_t            cfg_o
);
  import pfc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SYNC_FIRST:  cfg_d.sync_first  = cfg_data_i[ByteW-1:0];
        CFG_SYNC_SECOND: cfg_d.sync_second = cfg_data_i[ByteW-1:0];
        CFG_MAX_LEN:     cfg_d.max_len     = cfg_data_i[LenW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= '0;
      cfg_q.sync_second <= '0;
      cfg_q.max_len     <= MaxLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/pfc_parser.sv
// ----------------------------------------------------------------------------
// pfc_parser
// Frame parse state and the per-beat update; gives at most one verdict per beat.
// ----------------------------------------------------------------------------
module pfc_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [pfc_pkg::ByteW-1:0]    data_byte_i,
  input  logic                         frame_start_i,
  input  pfc_pkg::cfg_t                cfg_i,
  output pfc_pkg::result_t             result_o
);
  import pfc_pkg::*;

  phase_e           phase_q, phase_d, phase_cur;
  logic [ByteW-1:0] type_q, type_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  rem_q, rem_d, rem_dec;
  logic [LenW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0] chk_hi_q, chk_hi_d;
  logic [LenW-1:0]  len_full;
  logic [LenW-1:0]  rx_sum;
  logic             emit;
  verdict_e         verdict;

  assign len_full = {len_q[LenW-1:ByteW], data_byte_i};
  assign rem_dec  = rem_q - LenW'(1);
  assign rx_sum   = {chk_hi_q, data_byte_i};

  always_comb begin
    phase_cur = frame_start_i ? PH_HUNT : phase_q;
    phase_d   = phase_cur;
    type_d    = type_q;
    len_d     = len_q;
    rem_d     = rem_q;
    sum_d     = sum_q;
    chk_hi_d  = chk_hi_q;
    emit      = 1'b0;
    verdict   = V_VALID;

    unique case (phase_cur)
      PH_HUNT: begin
        type_d   = '0;
        len_d    = '0;
        rem_d    = '0;
        sum_d    = '0;
        chk_hi_d = '0;
        if (data_byte_i != cfg_i.sync_first) begin
          emit    = 1'b1;
          verdict = V_BAD_SYNC1;
        end else begin
          phase_d = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (data_byte_i != cfg_i.sync_second) begin
          emit    = 1'b1;
          verdict = V_BAD_SYNC2;
        end else begin
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d  = data_byte_i;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {data_byte_i, ByteW'(0)};
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d = len_full;
        if (len_full > cfg_i.max_len) begin
          emit    = 1'b1;
          verdict = V_TOO_LONG;
        end else begin
          rem_d   = len_full;
          sum_d   = '0;
          phase_d = (len_full == '0) ? PH_SUM_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_d = sum_q + LenW'(data_byte_i);
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d = PH_SUM_HI;
        end
      end
      PH_SUM_HI: begin
        chk_hi_d = data_byte_i;
        phase_d  = PH_SUM_LO;
      end
      PH_SUM_LO: begin
        emit    = 1'b1;
        verdict = (rx_sum == sum_q) ? V_VALID : V_BAD_SUM;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase

    // Every verdict sends the parser back to hunting.
    if (emit) begin
      phase_d = PH_HUNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      type_q   <= '0;
      len_q    <= '0;
      rem_q    <= '0;
      sum_q    <= '0;
      chk_hi_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      sum_q    <= sum_d;
      chk_hi_q <= chk_hi_d;
    end
  end

  assign result_o.valid      = step_i & emit;
  assign result_o.verdict    = verdict;
  assign result_o.frame_type = type_d;
  assign result_o.length     = len_d;

endmodule

// File: hdl/pfc_out_reg.sv
// ----------------------------------------------------------------------------
// pfc_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module pfc_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfc_pkg::result_t              result_i,
  output logic                          advance_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pfc_pkg::VerdictW-1:0]  verdict_o,
  output logic [pfc_pkg::ByteW-1:0]     frame_type_o,
  output logic [pfc_pkg::LenW-1:0]      payload_length_o
);
  import pfc_pkg::*;

  logic             valid_q;
  verdict_e         verdict_q;
  logic [ByteW-1:0] type_q;
  logic [LenW-1:0]  len_q;

  // The register may take a new beat when it is empty or being drained.
  assign advance_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && result_i.valid) begin
      verdict_q <= result_i.verdict;
      type_q    <= result_i.frame_type;
      len_q     <= result_i.length;
    end
  end

  assign out_valid_o      = valid_q;
  assign verdict_o        = verdict_q;
  assign frame_type_o     = type_q;
  assign payload_length_o = len_q;

endmodule

// File: hdl/packet_frame_checker.sv
// ----------------------------------------------------------------------------
// packet_frame_checker
// Byte-serial checker for sync/type/length/payload/checksum framed packets.
// ----------------------------------------------------------------------------
// The final byte of a frame is captured in the input register; its verdict is
// then registered in the result register. Throughput: one byte beat per cycle
// while the output is not stalled; the parse update is a single pass of logic
// between the input register and the result register.
// Reset: rst_ni clears the handshake state and the parser to hunting for the
// first sync byte; the registers return to sync bytes 0 and a limit of 1024.
// ----------------------------------------------------------------------------
module packet_frame_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [pfc_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [pfc_pkg::CfgDataW-1:0]      cfg_data_i,
  // Byte input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pfc_pkg::ByteW-1:0]         data_byte_i,
  input  logic                              frame_start_i,
  // Verdict output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pfc_pkg::VerdictW-1:0]      verdict_o,
  output logic [pfc_pkg::ByteW-1:0]         frame_type_o,
  output logic [pfc_pkg::LenW-1:0]          payload_length_o
);
  import pfc_pkg::*;

  cfg_t             cfg;
  result_t          result;
  logic             advance;
  logic             step;
  logic             in_accept;
  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             start_q;

  pfc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The input register holds one beat. It is processed whenever the result
  // register can take whatever that beat produces, so a full input register
  // only stalls the source while the result register is itself stalled.
  assign step       = in_valid_q & advance;
  assign in_stall_o = in_valid_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q  <= data_byte_i;
      start_q <= frame_start_i;
    end
  end

  // The parser advances its frame state once per processed beat and reports
  // a verdict on the beats that end or abort a frame.
  pfc_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (byte_q),
    .frame_start_i (start_q),
    .cfg_i         (cfg),
    .result_o      (result)
  );

  pfc_out_reg u_out_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .result_i         (result),
    .advance_o        (advance),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .verdict_o        (verdict_o),
    .frame_type_o     (frame_type_o),
    .payload_length_o (payload_length_o)
  );

endmodule
